// ----- rtl/core/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types for the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;
	localparam int POOL_WORDS   = 4096;
	localparam int ADDR_W       = $clog2(POOL_WORDS);
	localparam int WORD_W       = 13;
	localparam int HEADER_WORDS = 3;
	localparam int STEP_W       = ADDR_W + 1;

	localparam logic [WORD_W-1:0] GROW_RESET  = WORD_W'(32);
	localparam logic [WORD_W-1:0] SPLIT_RESET = WORD_W'(8);

	localparam logic CFG_MIN_GROW  = 1'b0;
	localparam logic CFG_MIN_SPLIT = 1'b1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_OOM  = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;
endpackage

// ----- rtl/core/first_fit_free_list_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit allocator with address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
// channel  | direction | handshake             | payload
// in       | in        | in_valid / in_ready   | operation, request_bytes, release_address
// out      | out       | out_valid / out_ready | data_address, status
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. Each header word goes through the single-port header
// RAM, read then written. An allocate reads next link and size per node checked,
// then unlinks the block and raises the result beat (a split first sizes and
// links the rest); a miss reads the last link, checks growth, then sizes and
// links the grown block (out of memory ends right there). A free reads the next
// link per node walked, links the block, checks both merges and raises the
// result beat; a merge adds a size read, write and unlink. Sentinel words 1 and
// 2 sit in registers set at reset; no clearing pass. A stalled result holds in
// the output register; the next item is taken once the result beat has gone.
module first_fit_free_list_allocator_unit
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [15:0]              request_bytes,
	input  logic [11:0]              release_address,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [11:0]              data_address,
	output logic                     status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [ffa_pkg::WORD_W-1:0] cfg_data
);
	import ffa_pkg::*;

	// micro-op sequencer: every header access is a read (R) or a write (W)
	localparam logic [5:0] S_IDLE   = 6'd0;
	localparam logic [5:0] S_A_NX   = 6'd1;  // read next of cur
	localparam logic [5:0] S_A_NXW  = 6'd2;
	localparam logic [5:0] S_A_SZ   = 6'd3;  // read size of cur
	localparam logic [5:0] S_A_SZW  = 6'd4;
	localparam logic [5:0] S_GROW   = 6'd5;
	localparam logic [5:0] S_G_W0   = 6'd6;  // grown block: size
	localparam logic [5:0] S_LB_RP  = 6'd7;  // link_before: read prev(at)
	localparam logic [5:0] S_LB_RPW = 6'd8;
	localparam logic [5:0] S_LB_W1  = 6'd9;
	localparam logic [5:0] S_LB_W2  = 6'd10;
	localparam logic [5:0] S_LB_W3  = 6'd11;
	localparam logic [5:0] S_LB_W4  = 6'd12;
	localparam logic [5:0] S_GR_SZ  = 6'd13; // grant: read size
	localparam logic [5:0] S_GR_SZW = 6'd14;
	localparam logic [5:0] S_SP_W0  = 6'd15; // split: size rest
	localparam logic [5:0] S_SP_W1  = 6'd16; // size b
	localparam logic [5:0] S_LA_RN  = 6'd17; // link_after: read next(b)
	localparam logic [5:0] S_LA_RNW = 6'd18;
	localparam logic [5:0] S_LA_W1  = 6'd19;
	localparam logic [5:0] S_LA_W2  = 6'd20;
	localparam logic [5:0] S_LA_W3  = 6'd21;
	localparam logic [5:0] S_LA_W4  = 6'd22;
	localparam logic [5:0] S_UL_RP  = 6'd23; // unlink: read prev
	localparam logic [5:0] S_UL_RPW = 6'd24;
	localparam logic [5:0] S_UL_RN  = 6'd25;
	localparam logic [5:0] S_UL_RNW = 6'd26;
	localparam logic [5:0] S_UL_W1  = 6'd27;
	localparam logic [5:0] S_UL_W2  = 6'd28;
	localparam logic [5:0] S_F_NX   = 6'd29; // free walk: read next
	localparam logic [5:0] S_F_NXW  = 6'd30;
	localparam logic [5:0] S_F_CHK  = 6'd31;
	localparam logic [5:0] S_M_RP   = 6'd32; // read prev(b)
	localparam logic [5:0] S_M_RPW  = 6'd33;
	localparam logic [5:0] S_M_RN   = 6'd34; // read next(keep)
	localparam logic [5:0] S_M_RNW  = 6'd35;
	localparam logic [5:0] S_M_RLS  = 6'd36; // read size lo
	localparam logic [5:0] S_M_RLSW = 6'd37;
	localparam logic [5:0] S_M_RHS  = 6'd38; // read size hi
	localparam logic [5:0] S_M_RHSW = 6'd39;
	localparam logic [5:0] S_M_WS   = 6'd40;
	localparam logic [5:0] S_RESULT = 6'd41;

	// return points of the shared link/unlink subroutines
	localparam logic [1:0] RET_GRANT = 2'd0;
	localparam logic [1:0] RET_MERGE = 2'd1;
	localparam logic [1:0] RET_RES   = 2'd3;

	logic [5:0]  state_q;
	logic [1:0]  lb_ret_q, ul_ret_q;
	logic        merge2_q;          // second merge in progress
	logic [WORD_W:0] sz_q;
	word_t       mgrow_q, msplit_q, hwm_q;
	addr_t       cur_q, blk_q, at_q, nb_q, p_q, lo_q, hi_q, keep_q;
	word_t       have_q, los_q;
	logic [STEP_W-1:0] steps_q;
	logic [11:0] res_addr_q;
	logic        res_st_q;
	logic        out_valid_q;

	// header RAM plus register copy of the sentinel links
	word_t mem [POOL_WORDS];
	word_t rdata_q;
	addr_t snext_q, sprev_q;
	addr_t raddr_q;
	logic  mem_we, mem_re;
	addr_t maddr;
	word_t mwdata;
	word_t rval;

	always_ff @(posedge clk) begin
		if (mem_we) mem[maddr] <= mwdata;
		if (mem_re) rdata_q <= mem[maddr];
	end

	// words 1, 2 come from the sentinel registers
	always_comb begin
		unique case (raddr_q)
			addr_t'(1): rval = word_t'(snext_q);
			addr_t'(2): rval = word_t'(sprev_q);
			default:    rval = rdata_q;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign data_address = res_addr_q;
	assign status = res_st_q;

	logic [16:0] words_w;
	logic [WORD_W:0]   nbw;
	logic [WORD_W+1:0] sum_w;
	assign words_w = ({1'b0, request_bytes} + 17'd8) >> 3;
	assign nbw = (sz_q < {1'b0, mgrow_q}) ? {1'b0, mgrow_q} : sz_q;
	assign sum_w = {2'b0, hwm_q} + {1'b0, nbw};

	// memory port driven by state
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		maddr  = '0;
		mwdata = '0;
		unique case (state_q)
			S_A_NX:  begin mem_re = 1'b1; maddr = cur_q + addr_t'(1); end
			S_A_SZ:  begin mem_re = 1'b1; maddr = cur_q; end
			S_G_W0:  begin mem_we = 1'b1; maddr = blk_q; mwdata = word_t'(nbw); end
			S_LB_RP: begin mem_re = 1'b1; maddr = at_q + addr_t'(2); end
			S_LB_W1: begin mem_we = 1'b1; maddr = nb_q + addr_t'(1); mwdata = word_t'(at_q); end
			S_LB_W2: begin mem_we = 1'b1; maddr = at_q + addr_t'(2); mwdata = word_t'(nb_q); end
			S_LB_W3: begin mem_we = 1'b1; maddr = p_q + addr_t'(1); mwdata = word_t'(nb_q); end
			S_LB_W4: begin mem_we = 1'b1; maddr = nb_q + addr_t'(2); mwdata = word_t'(p_q); end
			S_GR_SZ: begin mem_re = 1'b1; maddr = cur_q; end
			S_SP_W0: begin
				mem_we = 1'b1; maddr = nb_q;
				mwdata = have_q - word_t'(sz_q) - word_t'(HEADER_WORDS);
			end
			S_SP_W1: begin mem_we = 1'b1; maddr = cur_q; mwdata = word_t'(sz_q); end
			S_LA_RN: begin mem_re = 1'b1; maddr = cur_q + addr_t'(1); end
			S_LA_W1: begin mem_we = 1'b1; maddr = cur_q + addr_t'(1); mwdata = word_t'(nb_q); end
			S_LA_W2: begin mem_we = 1'b1; maddr = nb_q + addr_t'(2); mwdata = word_t'(cur_q); end
			S_LA_W3: begin mem_we = 1'b1; maddr = nb_q + addr_t'(1); mwdata = word_t'(p_q); end
			S_LA_W4: begin mem_we = 1'b1; maddr = p_q + addr_t'(2); mwdata = word_t'(nb_q); end
			S_UL_RP: begin mem_re = 1'b1; maddr = hi_q + addr_t'(2); end
			S_UL_RN: begin mem_re = 1'b1; maddr = hi_q + addr_t'(1); end
			S_UL_W1: begin mem_we = 1'b1; maddr = p_q + addr_t'(1); mwdata = word_t'(nb_q); end
			S_UL_W2: begin mem_we = 1'b1; maddr = nb_q + addr_t'(2); mwdata = word_t'(p_q); end
			S_F_NX:  begin mem_re = 1'b1; maddr = cur_q + addr_t'(1); end
			S_M_RP:  begin mem_re = 1'b1; maddr = blk_q + addr_t'(2); end
			S_M_RN:  begin mem_re = 1'b1; maddr = keep_q + addr_t'(1); end
			S_M_RLS: begin mem_re = 1'b1; maddr = lo_q; end
			S_M_RHS: begin mem_re = 1'b1; maddr = hi_q; end
			S_M_WS:  begin
				mem_we = 1'b1; maddr = lo_q;
				mwdata = los_q + rval + word_t'(HEADER_WORDS);
			end
			default: ;
		endcase
	end

	// sentinel link writes land in the registers too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snext_q <= '0;
			sprev_q <= '0;
		end else if (mem_we) begin
			if (maddr == addr_t'(1)) snext_q <= addr_t'(mwdata);
			if (maddr == addr_t'(2)) sprev_q <= addr_t'(mwdata);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) raddr_q <= maddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mgrow_q  <= GROW_RESET;
			msplit_q <= SPLIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_GROW:  mgrow_q  <= cfg_data;
				CFG_MIN_SPLIT: msplit_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			hwm_q       <= word_t'(HEADER_WORDS);
			lb_ret_q    <= RET_GRANT;
			ul_ret_q    <= RET_RES;
			merge2_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					sz_q  <= (WORD_W+1)'(words_w);
					steps_q <= '0;
					cur_q <= '0;
					res_addr_q <= '0;
					res_st_q <= ST_DONE;
					if (operation == OP_ALLOC) state_q <= S_A_NX;
					else if (release_address < 12'(2*HEADER_WORDS) ||
						{1'b0, release_address - 12'(HEADER_WORDS)} >= hwm_q)
						state_q <= S_RESULT;
					else begin
						blk_q <= addr_t'(release_address - 12'(HEADER_WORDS));
						state_q <= S_F_NX;
					end
				end
				// allocate walk: cur_q holds node whose next is fetched
				S_A_NX: state_q <= S_A_NXW;
				S_A_NXW: begin
					cur_q <= addr_t'(rval);
					if (addr_t'(rval) == '0 || steps_q == STEP_W'(POOL_WORDS))
						state_q <= S_GROW;
					else state_q <= S_A_SZ;
				end
				S_A_SZ: state_q <= S_A_SZW;
				S_A_SZW: begin
					steps_q <= steps_q + 1'b1;
					if ({1'b0, rval} >= sz_q) state_q <= S_GR_SZ;
					else state_q <= S_A_NX;
				end
				S_GROW: begin
					if (sum_w >= (WORD_W+2)'(POOL_WORDS)) begin
						res_st_q <= ST_OOM;
						state_q  <= S_RESULT;
					end else begin
						blk_q <= addr_t'(hwm_q);
						hwm_q <= word_t'(sum_w + (WORD_W+2)'(HEADER_WORDS));
						state_q <= S_G_W0;
					end
				end
				S_G_W0: begin
					at_q <= '0; nb_q <= blk_q; cur_q <= blk_q;
					lb_ret_q <= RET_GRANT;
					state_q <= S_LB_RP;
				end
				S_LB_RP: state_q <= S_LB_RPW;
				S_LB_RPW: begin p_q <= addr_t'(rval); state_q <= S_LB_W1; end
				S_LB_W1: state_q <= S_LB_W2;
				S_LB_W2: state_q <= S_LB_W3;
				S_LB_W3: state_q <= S_LB_W4;
				S_LB_W4: state_q <= (lb_ret_q == RET_GRANT) ? S_GR_SZ : S_M_RP;
				S_GR_SZ: state_q <= S_GR_SZW;
				S_GR_SZW: begin
					have_q <= rval;
					res_addr_q <= 12'(cur_q + addr_t'(HEADER_WORDS));
					nb_q <= cur_q + addr_t'(HEADER_WORDS) + addr_t'(sz_q);
					hi_q <= cur_q;
					ul_ret_q <= RET_RES;
					if ({2'b0, rval} >= {2'b0, msplit_q} + (WORD_W+2)'(HEADER_WORDS)
						+ {1'b0, sz_q})
						state_q <= S_SP_W0;
					else state_q <= (cur_q == '0) ? S_RESULT : S_UL_RP;
				end
				S_SP_W0: state_q <= S_SP_W1;
				S_SP_W1: state_q <= S_LA_RN;
				S_LA_RN: state_q <= S_LA_RNW;
				S_LA_RNW: begin p_q <= addr_t'(rval); state_q <= S_LA_W1; end
				S_LA_W1: state_q <= S_LA_W2;
				S_LA_W2: state_q <= S_LA_W3;
				S_LA_W3: state_q <= S_LA_W4;
				S_LA_W4: state_q <= (cur_q == '0) ? S_RESULT : S_UL_RP;
				// unlink hi_q
				S_UL_RP: state_q <= S_UL_RPW;
				S_UL_RPW: begin p_q <= addr_t'(rval); state_q <= S_UL_RN; end
				S_UL_RN: state_q <= S_UL_RNW;
				S_UL_RNW: begin nb_q <= addr_t'(rval); state_q <= S_UL_W1; end
				S_UL_W1: state_q <= S_UL_W2;
				S_UL_W2: state_q <= (ul_ret_q == RET_MERGE) ? S_M_RN : S_RESULT;
				// free walk
				S_F_NX: state_q <= S_F_NXW;
				S_F_NXW: begin cur_q <= addr_t'(rval); state_q <= S_F_CHK; end
				S_F_CHK: begin
					if (cur_q == '0 || {1'b0, cur_q} >= {1'b0, blk_q}) begin
						at_q <= cur_q; nb_q <= blk_q;
						lb_ret_q <= RET_MERGE;
						state_q <= S_LB_RP;
					end else if (steps_q + 1'b1 == STEP_W'(POOL_WORDS)) begin
						at_q <= '0; nb_q <= blk_q;
						lb_ret_q <= RET_MERGE;
						state_q <= S_LB_RP;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= S_F_NX;
					end
				end
				S_M_RP: state_q <= S_M_RPW;
				S_M_RPW: begin
					lo_q <= addr_t'(rval); hi_q <= blk_q; keep_q <= blk_q;
					merge2_q <= 1'b0;
					state_q <= S_M_RLS;
				end
				S_M_RN: state_q <= S_M_RNW;
				S_M_RNW: begin
					lo_q <= keep_q; hi_q <= addr_t'(rval);
					merge2_q <= 1'b1;
					state_q <= S_M_RLS;
				end
				S_M_RLS: state_q <= S_M_RLSW;
				S_M_RLSW: begin
					los_q <= rval;
					if (lo_q == '0 || hi_q == '0 ||
						{2'b0, lo_q} + (ADDR_W+2)'(HEADER_WORDS) + (ADDR_W+2)'(rval)
						!= (ADDR_W+2)'(hi_q))
						state_q <= merge2_q ? S_RESULT : S_M_RN;
					else state_q <= S_M_RHS;
				end
				S_M_RHS: state_q <= S_M_RHSW;
				S_M_RHSW: state_q <= S_M_WS;
				S_M_WS: begin
					if (!merge2_q) keep_q <= lo_q;
					ul_ret_q <= merge2_q ? RET_RES : RET_MERGE;
					state_q <= S_UL_RP;
				end
				S_RESULT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !out_valid)
		else $error("item accepted while result pending");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |=> out_valid)
		else $error("result not presented");
	a_oom_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OOM) |-> (data_address == 12'd0))
		else $error("address on out of memory");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("header write while idle");
`endif
endmodule
